// ----- rtl/ptss_pkg.sv -----
// Package: types, exception word table and constants for the past-tense suffix stripper.
package ptss_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int EXC_COUNT   = 18;
	localparam int EXC_CHARS   = 10;
	localparam int TAIL_W      = 48;

	localparam logic [EXC_COUNT-1:0] EXC_ALL = '1;

	// Left-justified exception words, padded with spaces to EXC_CHARS bytes.
	localparam logic [8*EXC_CHARS-1:0] EXC_WORD [EXC_COUNT] = '{
		"adhered   ", "cancelled ", "compelled ", "compelled ", "cupelled  ",
		"dispelled ", "expelled  ", "gospelled ", "impelled  ", "lapelled  ",
		"propelled ", "rappelled ", "reexpelled", "repelled  ", "repelled  ",
		"respelled ", "revered   ", "stirred   "
	};

	localparam logic [3:0] EXC_LEN [EXC_COUNT] = '{
		4'd7, 4'd9, 4'd9, 4'd9, 4'd8, 4'd9, 4'd8, 4'd9, 4'd8, 4'd8,
		4'd9, 4'd9, 4'd10, 4'd8, 4'd8, 4'd9, 4'd7, 4'd7
	};

	typedef struct packed {
		logic [7:0] char_code;
		logic       word_end;
	} in_t;

	typedef struct packed {
		logic       changed;
		logic [5:0] keep_length;
		logic       last_becomes_y;
		logic       exception_hit;
		logic [4:0] exception_index;
	} out_t;

	typedef struct packed {
		logic       chg;
		logic       to_y;
		logic [1:0] drop;
	} rule_t;

endpackage

// ----- rtl/ptss_ram.sv -----
// Generic single-port-write, registered-read RAM.
module ptss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ----- rtl/past_tense_suffix_stripper_core.sv -----
// Top level: past-tense suffix stripper, word state kept in a registered-read RAM.
// Result path: a word_end character is registered in item_s1, and its result in out_q;
// out_q loads only when it is empty or its held result is taken, and out_valid rises with it.
// Throughput: one character per cycle unless a word_end waits on a held result; the state
// RAM read/modify/write loop forwards the last written state when consecutive characters follow.
// Reset: arst_n clears the pipeline and output valid flags; the state RAM reads as
// an empty word until its first write.
module past_tense_suffix_stripper_core #(
	parameter int MAX_LEN = ptss_pkg::MAX_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ptss_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ptss_pkg::out_t out_data
);
	import ptss_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEN + 2);
	localparam int KW    = (CNT_W > 6) ? CNT_W : 6;
	localparam int ST_W  = CNT_W + TAIL_W + EXC_COUNT;
	localparam logic [ST_W-1:0] ST_RESET = {{CNT_W{1'b0}}, {TAIL_W{1'b0}}, EXC_ALL};

	logic            valid_s1;
	in_t             item_s1;
	logic            fwd_s1;
	logic [ST_W-1:0] wdata_q;
	logic            st_vld_q;
	logic            out_valid_q;
	out_t            out_q;

	logic [ST_W-1:0]      rd_data;
	logic [ST_W-1:0]      state_cur;
	logic [ST_W-1:0]      state_nx;
	logic [CNT_W-1:0]     cnt;
	logic [CNT_W-1:0]     n_nx;
	logic [TAIL_W-1:0]    tail;
	logic [TAIL_W-1:0]    tail_nx;
	logic [EXC_COUNT-1:0] alive;
	logic [EXC_COUNT-1:0] alive_nx;
	logic [3:0]           pos;
	logic                 hit;
	logic [4:0]           hit_idx;
	rule_t                rule;
	logic [KW-1:0]        keep_full;
	out_t                 res;
	logic                 adv;
	logic                 accept;
	logic                 out_load;

	function automatic logic vowel5(input logic [7:0] c);
		return c == "a" || c == "u" || c == "e" || c == "o" || c == "i";
	endfunction

	function automatic logic vowel6(input logic [7:0] c);
		return vowel5(c) || c == "y";
	endfunction

	function automatic rule_t suffix_rule(input logic [CNT_W-1:0] n,
			input logic [TAIL_W-1:0] t);
		rule_t      r;
		logic [7:0] t1;
		logic [7:0] t2;
		logic [7:0] t3;
		logic [7:0] t4;
		logic [7:0] t5;
		logic [7:0] t6;
		logic       gt5;
		t1  = t[7:0];
		t2  = t[15:8];
		t3  = t[23:16];
		t4  = t[31:24];
		t5  = t[39:32];
		t6  = t[47:40];
		gt5 = n > CNT_W'(5);
		r   = '{chg: 1'b1, to_y: 1'b0, drop: 2'd2};
		if (n <= CNT_W'(4)) begin
			r.chg = 1'b0;
		end else if (n > CNT_W'(6) && t3 == "i" && t2 == "n" && t1 == "g") begin
			r.chg = 1'b0;
		end else if (!(t2 == "e" && t1 == "d")) begin
			r.chg = 1'b0;
		end else if (t3 == "i") begin
			r.to_y = 1'b1;
		end else if (t3 == "u") begin
			r.drop = 2'd1;
		end else if (vowel5(t3)) begin
			r.chg = 1'b0;
		end else if (vowel6(t4) && (t3 == "x" || t3 == "y" || t3 == "r" || t3 == "l"
				|| t3 == "w")) begin
			r.drop = 2'd2;
		end else if (vowel5(t4)) begin
			if (gt5 && (vowel5(t5) || (t5 == "h" && t4 == "e" && t3 == "n"))) begin
				r.drop = 2'd2;
			end else begin
				r.drop = 2'd1;
			end
		end else if (t4 == t3 && t3 != "l") begin
			r.drop = gt5 ? 2'd3 : 2'd2;
		end else if (gt5 && t3 == "g" && t4 == "n" && t5 == "a" && t6 == "r") begin
			r.drop = 2'd1;
		end
		return r;
	endfunction

	ptss_ram #(
		.WIDTH(ST_W),
		.DEPTH(1)
	) u_state_ram (
		.clk    (clk),
		.wr_en  (adv),
		.wr_addr(1'b0),
		.wr_data(state_nx),
		.rd_addr(1'b0),
		.rd_data(rd_data)
	);

	assign adv      = valid_s1 && (!item_s1.word_end || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign out_load = adv && item_s1.word_end;

	always_comb begin
		state_cur = fwd_s1 ? wdata_q : (st_vld_q ? rd_data : ST_RESET);
		cnt       = state_cur[ST_W-1 -: CNT_W];
		tail      = state_cur[EXC_COUNT +: TAIL_W];
		alive     = state_cur[EXC_COUNT-1:0];
		pos       = (cnt < CNT_W'(EXC_CHARS)) ? cnt[3:0] : 4'd0;
		for (int e = 0; e < EXC_COUNT; e++) begin
			alive_nx[e] = alive[e] && (cnt < CNT_W'(EXC_LEN[e]))
				&& (EXC_WORD[e][8*(EXC_CHARS-1-int'(pos)) +: 8] == item_s1.char_code);
		end
		n_nx    = (cnt < CNT_W'(MAX_LEN + 1)) ? cnt + CNT_W'(1) : cnt;
		tail_nx = {tail[TAIL_W-9:0], item_s1.char_code};
		hit     = 1'b0;
		hit_idx = 5'd0;
		for (int e = EXC_COUNT - 1; e >= 0; e--) begin
			if (alive_nx[e] && n_nx == CNT_W'(EXC_LEN[e])) begin
				hit     = 1'b1;
				hit_idx = 5'(e);
			end
		end
		rule      = suffix_rule(n_nx, tail_nx);
		keep_full = KW'(n_nx - CNT_W'(rule.drop));
		res       = '0;
		if (n_nx <= CNT_W'(MAX_LEN)) begin
			if (hit) begin
				res.changed         = 1'b1;
				res.exception_hit   = 1'b1;
				res.exception_index = hit_idx;
			end else if (rule.chg) begin
				res.changed        = 1'b1;
				res.keep_length    = keep_full[5:0];
				res.last_becomes_y = rule.to_y;
			end
		end
		state_nx = item_s1.word_end ? ST_RESET : {n_nx, tail_nx, alive_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			st_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			fwd_s1 <= accept && adv;
			if (adv) begin
				st_vld_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			wdata_q <= state_nx;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_hit_keep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.exception_hit |->
			out_data.changed && out_data.keep_length == 6'd0 && !out_data.last_becomes_y)
		else $error("exception transfer carries a stem length");

	a_unchanged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.changed |-> out_data == '0)
		else $error("unchanged transfer carries nonzero fields");

	a_end_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> wdata_q == ST_RESET)
		else $error("word state not re-armed after word end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !out_load)
		else $error("result register overwritten while held");
`endif

endmodule

// ----- tb/sv/past_tense_suffix_stripper_core_test.sv -----
// Testbench for the past-tense suffix stripper: directed words, random word stream, stem checks.
`timescale 1ns / 1ps

module past_tense_suffix_stripper_core_test;

	import ptss_pkg::*;

	localparam int MAX_LEN      = MAX_LEN_DEF;
	localparam int EXC_N        = EXC_COUNT;
	localparam int RANDOM_CHARS = 1050;
	localparam int QUIET_CHARS  = 200;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [4:0] IDX_ADHERED    = 5'd0;
	localparam logic [4:0] IDX_COMPELLED  = 5'd2;
	localparam logic [4:0] IDX_RAPPELLED  = 5'd11;
	localparam logic [4:0] IDX_REEXPELLED = 5'd12;
	localparam logic [4:0] IDX_REPELLED   = 5'd13;
	localparam logic [4:0] IDX_STIRRED    = 5'd17;

	localparam out_t NO_STEM = '0;

	typedef logic [7:0] octet_q_t [$];

	typedef struct packed {
		logic typed;
		out_t answer;
	} word_note_t;

	typedef struct {
		logic [7:0] pad;
		int         pad_n;
		string      text;
		bit         typed;
		out_t       answer;
	} probe_t;

	string exc_words [EXC_N] = '{
		"adhered", "cancelled", "compelled", "compelled", "cupelled",
		"dispelled", "expelled", "gospelled", "impelled", "lapelled",
		"propelled", "rappelled", "reexpelled", "repelled", "repelled",
		"respelled", "revered", "stirred"
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	logic [6:0]         word_len = '0;
	logic [47:0]        recent_chars = '0;
	logic [EXC_N-1:0]   exc_alive = '1;

	word_note_t word_note_q [$];
	out_t       answer_q [$];
	probe_t     probe_q [$];

	int  cycle_count = 0;
	int  chars_sent = 0;
	int  words_sent = 0;
	int  fail_count = 0;
	int  stems_seen = 0;
	int  hits_seen = 0;
	int  plain_seen = 0;
	bit  quiet_tail = 1'b0;
	bit  long_hold = 1'b0;

	past_tense_suffix_stripper_core #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$error("timeout after %0d cycles, %0d results outstanding", cycle_count, answer_q.size());
		$display("past_tense_suffix_stripper_core_test failed");
		$finish;
	end

	function automatic bit plain_vowel(input logic [7:0] c);
		return c inside {"a", "e", "i", "o", "u"};
	endfunction

	function automatic logic [6:0] ed_rule(input logic [6:0] n, output bit to_y);
		logic [7:0] c1, c2, c3, c4, c5, c6;
		c1 = recent_chars[7:0];
		c2 = recent_chars[15:8];
		c3 = recent_chars[23:16];
		c4 = recent_chars[31:24];
		c5 = recent_chars[39:32];
		c6 = recent_chars[47:40];
		to_y = 1'b0;
		if (n <= 4)
			return '0;
		if (n > 6 && c3 == "i" && c2 == "n" && c1 == "g")
			return '0;
		if (!(c2 == "e" && c1 == "d"))
			return '0;
		if (c3 == "i") begin
			to_y = 1'b1;
			return n - 7'd2;
		end
		if (c3 == "u")
			return n - 7'd1;
		if (plain_vowel(c3))
			return '0;
		if ((plain_vowel(c4) || c4 == "y") && c3 inside {"x", "y", "r", "l", "w"})
			return n - 7'd2;
		if (plain_vowel(c4)) begin
			if (n > 5 && (plain_vowel(c5) || (c5 == "h" && c4 == "e" && c3 == "n")))
				return n - 7'd2;
			return n - 7'd1;
		end
		if (c4 == c3 && c3 != "l") begin
			if (n > 5)
				return n - 7'd3;
		end else if (n > 5 && c3 == "g" && c4 == "n" && c5 == "a" && c6 == "r") begin
			return n - 7'd1;
		end
		return n - 7'd2;
	endfunction

	function automatic bit strip_char(input in_t x, output out_t res);
		logic [6:0] keep;
		bit         to_y;
		bit         found;
		found = 1'b0;
		res = NO_STEM;
		for (int e = 0; e < EXC_N; e++) begin
			if (exc_alive[e] && !(word_len < exc_words[e].len() &&
					exc_words[e][word_len] == x.char_code))
				exc_alive[e] = 1'b0;
		end
		if (word_len < MAX_LEN + 1)
			word_len = word_len + 7'd1;
		recent_chars = {recent_chars[39:0], x.char_code};
		if (!x.word_end)
			return 1'b0;
		if (word_len <= MAX_LEN) begin
			for (int e = 0; e < EXC_N; e++) begin
				if (!found && exc_alive[e] && exc_words[e].len() == word_len) begin
					found = 1'b1;
					res.changed = 1'b1;
					res.exception_hit = 1'b1;
					res.exception_index = e[4:0];
				end
			end
			if (!found) begin
				keep = ed_rule(word_len, to_y);
				if (keep != 0) begin
					res.changed = 1'b1;
					res.keep_length = keep[5:0];
					res.last_becomes_y = to_y;
				end
			end
		end
		word_len = '0;
		recent_chars = '0;
		exc_alive = '1;
		return 1'b1;
	endfunction

	function automatic out_t hit_answer(input logic [4:0] idx);
		out_t r;
		r = NO_STEM;
		r.changed = 1'b1;
		r.exception_hit = 1'b1;
		r.exception_index = idx;
		return r;
	endfunction

	function automatic void add_text(ref octet_q_t w, input string s);
		for (int i = 0; i < s.len(); i++)
			w.insert(w.size(), s[i]);
	endfunction

	function automatic logic [7:0] pick_letter();
		string common;
		common = "aeiouyxrlwhngdpbtsc";
		if ($urandom_range(0, 4) != 0)
			return common[$urandom_range(0, common.len() - 1)];
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic octet_q_t random_word();
		octet_q_t w;
		int       kind;
		int       n;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			add_text(w, exc_words[$urandom_range(0, EXC_N - 1)]);
			case ($urandom_range(0, 3))
				0: w.insert(w.size(), pick_letter());
				1: void'(w.pop_back());
				default: ;
			endcase
		end else if (kind < 84) begin
			n = $urandom_range(1, 9);
			repeat (n) w.insert(w.size(), pick_letter());
			case ($urandom_range(0, 9))
				0, 1: add_text(w, "ed");
				2: add_text(w, "ied");
				3: add_text(w, "ued");
				4: add_text(w, "eed");
				5: begin
					w.insert(w.size(), w[w.size() - 1]);
					add_text(w, "ed");
				end
				6: add_text(w, "ranged");
				7: add_text(w, "ing");
				8: add_text(w, "hened");
				default: ;
			endcase
		end else if (kind < 97) begin
			n = $urandom_range(1, 10);
			repeat (n) w.insert(w.size(), 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) != 0)
				add_text(w, "ed");
		end else begin
			n = $urandom_range(55, 70);
			repeat (n) w.insert(w.size(), pick_letter());
			if ($urandom_range(0, 3) != 0)
				add_text(w, "ed");
		end
		return w;
	endfunction

	task automatic send_char(input in_t x);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_word(input octet_q_t w, input bit typed, input out_t answer);
		in_t        x;
		word_note_t note;
		note.typed = typed;
		note.answer = answer;
		word_note_q.insert(word_note_q.size(), note);
		for (int i = 0; i < w.size(); i++) begin
			x.char_code = w[i];
			x.word_end = (i == w.size() - 1);
			send_char(x);
		end
		words_sent++;
	endtask

	task automatic add_probe(input logic [7:0] pad, input int pad_n, input string text,
			input bit typed, input out_t answer);
		probe_t p;
		p.pad = pad;
		p.pad_n = pad_n;
		p.text = text;
		p.typed = typed;
		p.answer = answer;
		probe_q.insert(probe_q.size(), p);
	endtask

	always @(posedge clk) begin : watch_input
		out_t       guess;
		word_note_t note;
		if (arst_n && in_valid && in_ready) begin
			if (strip_char(in_data, guess)) begin
				note = word_note_q.pop_front();
				answer_q.insert(answer_q.size(), note.typed ? note.answer : guess);
			end
		end
	end

	always @(posedge clk) begin : watch_output
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answer_q.size() == 0) begin
				$error("result with no word pending: %p", out_data);
				fail_count++;
			end else begin
				want = answer_q.pop_front();
				if (out_data.changed !== want.changed) begin
					$error("changed: expected %0d, got %0d", want.changed, out_data.changed);
					fail_count++;
				end
				if (out_data.keep_length !== want.keep_length) begin
					$error("keep_length: expected %0d, got %0d", want.keep_length,
						out_data.keep_length);
					fail_count++;
				end
				if (out_data.last_becomes_y !== want.last_becomes_y) begin
					$error("last_becomes_y: expected %0d, got %0d", want.last_becomes_y,
						out_data.last_becomes_y);
					fail_count++;
				end
				if (out_data.exception_hit !== want.exception_hit) begin
					$error("exception_hit: expected %0d, got %0d", want.exception_hit,
						out_data.exception_hit);
					fail_count++;
				end
				if (out_data.exception_index !== want.exception_index) begin
					$error("exception_index: expected %0d, got %0d", want.exception_index,
						out_data.exception_index);
					fail_count++;
				end
				if (want.exception_hit)
					hits_seen++;
				else if (want.changed)
					stems_seen++;
				else
					plain_seen++;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		octet_q_t w;
		int       base;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_probe(8'h00, 0, "adhered", 1'b1, hit_answer(IDX_ADHERED));
		add_probe(8'h00, 0, "compelled", 1'b1, hit_answer(IDX_COMPELLED));
		add_probe(8'h00, 0, "repelled", 1'b1, hit_answer(IDX_REPELLED));
		add_probe(8'h00, 0, "reexpelled", 1'b1, hit_answer(IDX_REEXPELLED));
		add_probe(8'h00, 0, "stirred", 1'b1, hit_answer(IDX_STIRRED));
		add_probe(8'h00, 0, "rappelled", 1'b1, hit_answer(IDX_RAPPELLED));
		add_probe(8'h00, 0, "ed", 1'b1, NO_STEM);
		add_probe(8'h00, 0, "a", 1'b1, NO_STEM);
		add_probe(8'h00, 0, "walked", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "tried", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "glued", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "freed", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "played", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "rained", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "shened", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "hoped", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "stopped", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "spelled", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "ranged", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "adhere", 1'b0, NO_STEM);
		add_probe(8'h00, 0, "singing", 1'b0, NO_STEM);
		add_probe("b", MAX_LEN - 2, "ed", 1'b0, NO_STEM);
		add_probe("a", MAX_LEN - 1, "ed", 1'b1, NO_STEM);
		add_probe(8'h00, 3, "\377", 1'b1, NO_STEM);
		add_probe(8'hFF, 5, "ed", 1'b0, NO_STEM);

		foreach (probe_q[i]) begin
			w.delete();
			repeat (probe_q[i].pad_n) w.insert(w.size(), probe_q[i].pad);
			add_text(w, probe_q[i].text);
			send_word(w, probe_q[i].typed, probe_q[i].answer);
		end

		long_hold = 1'b1;
		base = chars_sent;
		while (chars_sent - base < RANDOM_CHARS) begin
			quiet_tail = (chars_sent - base >= RANDOM_CHARS - QUIET_CHARS);
			send_word(random_word(), 1'b0, NO_STEM);
		end
		in_valid <= 1'b0;

		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("streamed %0d characters in %0d words over %0d cycles", chars_sent, words_sent,
			cycle_count);
		$display("answers checked: %0d stems, %0d exception hits, %0d unchanged", stems_seen,
			hits_seen, plain_seen);
		if (fail_count == 0)
			$display("past_tense_suffix_stripper_core_test passed");
		else
			$display("past_tense_suffix_stripper_core_test failed");
		$finish;
	end

endmodule
